// ----- design/pmx_pkg.sv -----
// Shared types and constants for the partially mapped crossover block.
`default_nettype none

package pmx_pkg;

    localparam int GENE_W    = 6;
    localparam int NUM_GENES = 64;

    typedef logic [GENE_W-1:0] gene_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SEG,
        ST_FILL,
        ST_WAIT,
        ST_FETCH,
        ST_SEND
    } top_state_t;

    typedef enum logic [1:0] {
        SIDE_IDLE,
        SIDE_WALK,
        SIDE_DONE
    } side_state_t;

    typedef struct packed {
        logic clear;
        logic seg_en;
        logic start;
        logic ack;
    } side_ctrl_t;

endpackage

`default_nettype wire

// ----- design/pmx_side.sv -----
// One child of the crossover: its mapping table, used bitmap, gene store and chain walker.
`default_nettype none

module pmx_side #(
    parameter int MAX_CITIES = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pmx_pkg::side_ctrl_t            ctrl,
    input  wire logic [$clog2(MAX_CITIES)-1:0]  pos,
    input  wire pmx_pkg::gene_t                 own_gene,
    input  wire pmx_pkg::gene_t                 other_gene,
    output logic                                done,
    output pmx_pkg::gene_t                      child_gene
);

    localparam int SW = $clog2(MAX_CITIES + 1);

    pmx_pkg::gene_t child_mem [MAX_CITIES];
    pmx_pkg::gene_t map_mem [pmx_pkg::NUM_GENES];

    pmx_pkg::side_state_t state_reg, state_next;
    logic [pmx_pkg::NUM_GENES-1:0] used_reg, used_next;
    pmx_pkg::gene_t g_reg, g_next;
    pmx_pkg::gene_t map_rd_reg;
    pmx_pkg::gene_t child_rd_reg;
    logic [SW-1:0] steps_reg, steps_next;

    logic walk_more;
    logic step;
    logic commit;

    assign walk_more = used_reg[g_reg] && (steps_reg != SW'(MAX_CITIES));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmx_pkg::SIDE_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = pmx_pkg::SIDE_WALK;
                end
            end
            pmx_pkg::SIDE_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = pmx_pkg::SIDE_DONE;
                end
            end
            pmx_pkg::SIDE_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = pmx_pkg::SIDE_IDLE;
                end
            end
            default:
            begin
                state_next = pmx_pkg::SIDE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        step   = 1'b0;
        commit = 1'b0;
        done   = 1'b0;
        unique case (state_reg)
            pmx_pkg::SIDE_IDLE:
            begin
            end
            pmx_pkg::SIDE_WALK:
            begin
                step   = walk_more;
                commit = !walk_more;
            end
            pmx_pkg::SIDE_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        g_next     = g_reg;
        steps_next = steps_reg;
        if (ctrl.start && (state_reg == pmx_pkg::SIDE_IDLE))
        begin
            g_next     = own_gene;
            steps_next = '0;
        end
        else if (step)
        begin
            g_next     = map_rd_reg;
            steps_next = steps_reg + SW'(1);
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (ctrl.clear)
        begin
            used_next = '0;
        end
        else if (ctrl.seg_en)
        begin
            used_next[other_gene] = 1'b1;
        end
        else if (commit)
        begin
            used_next[g_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmx_pkg::SIDE_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg     <= g_next;
        steps_reg <= steps_next;
    end

    // The map is read at the gene the walker holds in the next cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.seg_en && !used_reg[other_gene])
        begin
            map_mem[other_gene] <= own_gene;
        end
        map_rd_reg <= map_mem[g_next];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.seg_en)
        begin
            child_mem[pos] <= other_gene;
        end
        else if (commit)
        begin
            child_mem[pos] <= g_reg;
        end
        child_rd_reg <= child_mem[pos];
    end

    assign child_gene = child_rd_reg;

endmodule

`default_nettype wire

// ----- design/partially_mapped_crossover.sv -----
// Top level of the partially mapped crossover: parent load, sequencer and result output.
// Loading accepts a gene pair whenever parent_valid is high; the block is not ready while
// it computes or emits. Compute: a setup step, a pass over the segment positions, then a
// fill pass that, outside the segment, starts both chain walks (one map read a step) and
// waits for the longer. Output: each result comes from a registered child store read.
// Reset clears the sequencer, load count and used bitmaps; the stores need no clearing.
`default_nettype none

module partially_mapped_crossover #(
    parameter int MAX_CITIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           parent_valid,
    output logic                parent_ready,
    input  wire pmx_pkg::gene_t parent_a_city,
    input  wire pmx_pkg::gene_t parent_b_city,
    input  wire logic [5:0]     segment_start,
    input  wire logic [5:0]     segment_end,
    input  wire logic           last_gene,
    output logic                child_valid,
    input  wire logic           child_ready,
    output pmx_pkg::gene_t      child_a_city,
    output pmx_pkg::gene_t      child_b_city,
    output logic [5:0]          position,
    output logic                last_out
);

    localparam int AW = $clog2(MAX_CITIES);
    localparam int CW = $clog2(MAX_CITIES + 1);

    pmx_pkg::gene_t parent_a_mem [MAX_CITIES];
    pmx_pkg::gene_t parent_b_mem [MAX_CITIES];

    pmx_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] lo_reg, hi_reg, last_reg;
    pmx_pkg::gene_t pa_rd_reg, pb_rd_reg;

    pmx_pkg::side_ctrl_t ctrl;
    logic done_a, done_b;

    logic in_xfer;
    logic out_xfer;
    logic full;
    logic [CW-1:0] n_val;
    logic [6:0] nm1_ext;
    logic [6:0] s_cl, e_cl;
    logic [AW-1:0] lo_val, hi_val;
    logic in_seg;
    logic at_last;

    assign in_xfer  = parent_valid && parent_ready;
    assign out_xfer = child_valid && child_ready;
    assign full     = (count_reg == CW'(MAX_CITIES));
    assign n_val    = full ? count_reg : count_reg + CW'(1);
    assign nm1_ext  = 7'(n_val - CW'(1));
    assign s_cl     = (7'(segment_start) > nm1_ext) ? nm1_ext : 7'(segment_start);
    assign e_cl     = (7'(segment_end) > nm1_ext) ? nm1_ext : 7'(segment_end);
    assign lo_val   = (s_cl < e_cl) ? AW'(s_cl) : AW'(e_cl);
    assign hi_val   = (s_cl < e_cl) ? AW'(e_cl) : AW'(s_cl);
    assign in_seg   = (pos_reg >= lo_reg) && (pos_reg <= hi_reg);
    assign at_last  = (pos_reg == last_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmx_pkg::ST_LOAD:
            begin
                if (in_xfer && last_gene)
                begin
                    state_next = pmx_pkg::ST_SETUP;
                end
            end
            pmx_pkg::ST_SETUP:
            begin
                state_next = pmx_pkg::ST_SEG;
            end
            pmx_pkg::ST_SEG:
            begin
                if (pos_reg == hi_reg)
                begin
                    state_next = pmx_pkg::ST_FILL;
                end
            end
            pmx_pkg::ST_FILL:
            begin
                if (!in_seg)
                begin
                    state_next = pmx_pkg::ST_WAIT;
                end
                else if (at_last)
                begin
                    state_next = pmx_pkg::ST_FETCH;
                end
            end
            pmx_pkg::ST_WAIT:
            begin
                if (done_a && done_b)
                begin
                    state_next = at_last ? pmx_pkg::ST_FETCH : pmx_pkg::ST_FILL;
                end
            end
            pmx_pkg::ST_FETCH:
            begin
                state_next = pmx_pkg::ST_SEND;
            end
            pmx_pkg::ST_SEND:
            begin
                if (child_ready)
                begin
                    state_next = at_last ? pmx_pkg::ST_LOAD : pmx_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = pmx_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        parent_ready = 1'b0;
        child_valid  = 1'b0;
        ctrl         = '0;
        pos_next     = pos_reg;
        unique case (state_reg)
            pmx_pkg::ST_LOAD:
            begin
                parent_ready = 1'b1;
            end
            pmx_pkg::ST_SETUP:
            begin
                ctrl.clear = 1'b1;
                pos_next   = lo_reg;
            end
            pmx_pkg::ST_SEG:
            begin
                ctrl.seg_en = 1'b1;
                pos_next    = (pos_reg == hi_reg) ? '0 : pos_reg + AW'(1);
            end
            pmx_pkg::ST_FILL:
            begin
                if (!in_seg)
                begin
                    ctrl.start = 1'b1;
                end
                else
                begin
                    pos_next = at_last ? '0 : pos_reg + AW'(1);
                end
            end
            pmx_pkg::ST_WAIT:
            begin
                if (done_a && done_b)
                begin
                    ctrl.ack = 1'b1;
                    pos_next = at_last ? '0 : pos_reg + AW'(1);
                end
            end
            pmx_pkg::ST_FETCH:
            begin
            end
            pmx_pkg::ST_SEND:
            begin
                child_valid = 1'b1;
                if (child_ready && !at_last)
                begin
                    pos_next = pos_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_xfer)
        begin
            if (last_gene)
            begin
                count_next = '0;
            end
            else if (!full)
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmx_pkg::ST_LOAD;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && last_gene)
        begin
            lo_reg   <= lo_val;
            hi_reg   <= hi_val;
            last_reg <= AW'(nm1_ext);
        end
    end

    // Parent stores are read at the position the sequencer holds in the next cycle.
    always_ff @(posedge clk)
    begin
        if (in_xfer && !full)
        begin
            parent_a_mem[count_reg[AW-1:0]] <= parent_a_city;
            parent_b_mem[count_reg[AW-1:0]] <= parent_b_city;
        end
        pa_rd_reg <= parent_a_mem[pos_next];
        pb_rd_reg <= parent_b_mem[pos_next];
    end

    pmx_side #(
        .MAX_CITIES (MAX_CITIES)
    ) u_side_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pos        (pos_reg),
        .own_gene   (pa_rd_reg),
        .other_gene (pb_rd_reg),
        .done       (done_a),
        .child_gene (child_a_city)
    );

    pmx_side #(
        .MAX_CITIES (MAX_CITIES)
    ) u_side_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pos        (pos_reg),
        .own_gene   (pb_rd_reg),
        .other_gene (pa_rd_reg),
        .done       (done_b),
        .child_gene (child_b_city)
    );

    assign position = 6'(pos_reg);
    assign last_out = at_last;

    assert property (@(posedge clk) disable iff (!rst_n)
        !(parent_ready && child_valid))
        else $error("Input and output handshakes are open together.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && last_out) |=> parent_ready)
        else $error("Block did not return to loading after the final transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pmx_pkg::ST_SEG) |-> (pos_reg >= lo_reg && pos_reg <= hi_reg))
        else $error("Segment pass left the segment bounds.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_gene) |=> (count_reg == '0))
        else $error("Load count not cleared after the final gene pair.");

endmodule

`default_nettype wire
